/* hdl/lfht_pkg.sv */
// Types, sizes, codes and helpers shared by the lowest-free handle table.
package lfht_pkg;

    localparam int SLOTS        = 16384;
    localparam int PAYLOAD_BITS = 32;

    // Slot addressing
    localparam int SLOT_AW = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);

    // Valid bitmap: BM_BITS marks per memory word
    localparam int BM_LOG    = (SLOT_AW < 5) ? SLOT_AW : 5;
    localparam int BM_BITS   = 2 ** BM_LOG;
    localparam int WORD_LOG  = SLOT_AW - BM_LOG;
    localparam int WORDS     = 2 ** WORD_LOG;
    localparam int WORD_AW   = (WORD_LOG > 0) ? WORD_LOG : 1;
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORDS - 1);

    // Opcodes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_LOOKUP  = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FREE  = 2'd2;
    localparam logic [1:0] STATUS_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [14:0] slot_index;
        logic [31:0] entry_value;
    } lfht_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] result_index;
        logic [31:0] result_value;
        logic [14:0] used_count;
    } lfht_rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_CHECK,
        ST_RESULT
    } lfht_state_t;

    // Position of the lowest clear bit of a bitmap word.
    function automatic logic [BM_LOG-1:0] lowest_zero(input logic [BM_BITS-1:0] w);
        logic [BM_LOG-1:0] pos;
        pos = '0;
        for (int i = BM_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = BM_LOG'(i);
            end
        end
        return pos;
    endfunction

endpackage

/* hdl/lfht_ram.sv */
// Generic single-port synchronous RAM with registered read.
module lfht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                        aclk,
    input  logic                                        en,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                            wdata,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

/* hdl/lowest_free_handle_table_unit.sv */
// Top level of the lowest-free handle table: control FSM, bitmap and payload memories.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    lfht_req_t (opcode, slot_index, entry_value)
//   m_       out  m_valid/m_ready    lfht_rsp_t (status, result_index, result_value, used_count)
//
// One beat in gives one beat out. A lookup or release of an in-range slot passes
// DISPATCH, CHECK and RESULT; a range error, a full table or an unused opcode goes
// from DISPATCH straight to RESULT. An allocate reads the bitmap from the search
// hint upward, past every full word, until it finds a word with a clear bit (the
// bitmap RAM port is read one word a cycle). s_ready rises in the same cycle that
// the result beat appears at m_. After reset the bitmap, WORDS words (512 at 16384
// slots), is cleared one word a cycle, with s_ready low. A new beat is taken while
// the previous result still waits on m_ready.
module lowest_free_handle_table_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lfht_pkg::lfht_req_t s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output lfht_pkg::lfht_rsp_t m_payload
);
    import lfht_pkg::*;

    lfht_state_t state_reg, state_next;
    lfht_req_t   req_reg, req_next;
    lfht_rsp_t   res_reg, res_next;
    lfht_rsp_t   m_payload_reg, m_payload_next;
    logic        m_valid_reg, m_valid_next;

    logic [WORD_AW-1:0] word_reg, word_next;   // bitmap word under work
    logic [WORD_AW-1:0] hint_reg, hint_next;   // all words below are full
    logic [WORD_AW-1:0] clr_reg, clr_next;     // clearing sweep position
    logic [CNT_W-1:0]   count_reg, count_next;

    // Memory ports
    logic                    bm_en, bm_we;
    logic [WORD_AW-1:0]      bm_addr;
    logic [BM_BITS-1:0]      bm_wdata, bm_rdata;
    logic                    pl_en, pl_we;
    logic [SLOT_AW-1:0]      pl_addr;
    logic [PAYLOAD_BITS-1:0] pl_wdata, pl_rdata;

    // Request decode
    logic               req_alloc, req_access, req_range, table_full;
    logic [SLOT_AW-1:0] req_slot;
    logic [WORD_AW-1:0] req_word;
    logic [BM_LOG-1:0]  req_bit;

    // Bitmap word decode
    logic               bm_full_word, slot_hit;
    logic [BM_LOG-1:0]  free_bit;
    logic [SLOT_AW-1:0] free_slot;

    lfht_ram #(.WIDTH(BM_BITS), .DEPTH(WORDS)) u_bitmap (
        .aclk  (aclk),
        .en    (bm_en),
        .we    (bm_we),
        .addr  (bm_addr),
        .wdata (bm_wdata),
        .rdata (bm_rdata)
    );

    lfht_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(SLOTS)) u_payload (
        .aclk  (aclk),
        .en    (pl_en),
        .we    (pl_we),
        .addr  (pl_addr),
        .wdata (pl_wdata),
        .rdata (pl_rdata)
    );

    assign req_alloc  = (req_reg.opcode == OP_ALLOC);
    assign req_access = (req_reg.opcode == OP_LOOKUP) || (req_reg.opcode == OP_RELEASE);
    assign req_range  = (32'(req_reg.slot_index) >= 32'(SLOTS));
    assign table_full = (count_reg == CNT_W'(SLOTS));
    assign req_slot   = SLOT_AW'(req_reg.slot_index);
    assign req_word   = WORD_AW'(req_slot >> BM_LOG);
    assign req_bit    = req_slot[BM_LOG-1:0];

    assign bm_full_word = &bm_rdata;
    assign free_bit     = lowest_zero(bm_rdata);
    assign free_slot    = SLOT_AW'({word_reg, free_bit});
    assign slot_hit     = bm_rdata[req_bit];

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == LAST_WORD) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                priority if (req_alloc && !table_full) begin
                    state_next = ST_SCAN;
                end else if (req_access && !req_range) begin
                    state_next = ST_CHECK;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_SCAN: begin
                if (!bm_full_word) begin
                    state_next = ST_RESULT;
                end
            end
            ST_CHECK: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Datapath and memory control
    always_comb begin
        req_next       = req_reg;
        res_next       = res_reg;
        word_next      = word_reg;
        hint_next      = hint_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        m_payload_next = m_payload_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        bm_en          = 1'b0;
        bm_we          = 1'b0;
        bm_addr        = word_reg;
        bm_wdata       = bm_rdata;
        pl_en          = 1'b0;
        pl_we          = 1'b0;
        pl_addr        = req_slot;
        pl_wdata       = PAYLOAD_BITS'(req_reg.entry_value);

        unique case (state_reg)
            ST_CLEAR: begin
                bm_en    = 1'b1;
                bm_we    = 1'b1;
                bm_addr  = clr_reg;
                bm_wdata = '0;
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_payload;
                end
            end
            ST_DISPATCH: begin
                res_next.status       = STATUS_OK;
                res_next.result_index = 14'(req_reg.slot_index);
                res_next.result_value = '0;
                res_next.used_count   = 15'(count_reg);
                priority if (req_alloc) begin
                    if (table_full) begin
                        res_next.status       = STATUS_FULL;
                        res_next.result_index = '0;
                    end else begin
                        bm_en     = 1'b1;
                        bm_addr   = hint_reg;
                        word_next = hint_reg;
                    end
                end else if (req_access) begin
                    if (req_range) begin
                        res_next.status = STATUS_RANGE;
                    end else begin
                        bm_en     = 1'b1;
                        bm_addr   = req_word;
                        pl_en     = 1'b1;
                        word_next = req_word;
                    end
                end else begin
                    // unused opcode: plain echo
                end
            end
            ST_SCAN: begin
                if (bm_full_word) begin
                    word_next = word_reg + 1'b1;
                    bm_en     = 1'b1;
                    bm_addr   = word_reg + 1'b1;
                end else begin
                    bm_en                 = 1'b1;
                    bm_we                 = 1'b1;
                    bm_wdata              = bm_rdata | (BM_BITS'(1) << free_bit);
                    pl_en                 = 1'b1;
                    pl_we                 = 1'b1;
                    pl_addr               = free_slot;
                    count_next            = count_reg + 1'b1;
                    hint_next             = word_reg;
                    res_next.result_index = 14'(free_slot);
                    res_next.used_count   = 15'(count_reg + 1'b1);
                end
            end
            ST_CHECK: begin
                priority if (!slot_hit) begin
                    res_next.status = STATUS_FREE;
                end else if (req_reg.opcode == OP_LOOKUP) begin
                    res_next.result_value = 32'(pl_rdata);
                end else begin
                    bm_en               = 1'b1;
                    bm_we               = 1'b1;
                    bm_wdata            = bm_rdata & ~(BM_BITS'(1) << req_bit);
                    count_next          = count_reg - 1'b1;
                    res_next.used_count = 15'(count_reg - 1'b1);
                    if (word_reg < hint_reg) begin
                        hint_next = word_reg;
                    end
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_payload_next = res_reg;
                    m_valid_next   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            hint_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            hint_reg    <= hint_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        res_reg       <= res_next;
        word_reg      <= word_next;
        m_payload_reg <= m_payload_next;
    end

`ifndef ASSERT_OFF
    // count never passes the table size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SLOTS))
        else $error("allocated count above table size");

    // count moves by at most one per cycle
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + 1'b1) || (count_reg == $past(count_reg) - 1'b1)))
        else $error("allocated count jumped");

    // a successful search lands inside the table
    a_slot_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && !bm_full_word) |-> (32'(free_slot) < 32'(SLOTS)))
        else $error("allocated slot beyond table");

    // the search never runs off the last bitmap word
    a_scan_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && bm_full_word) |-> (word_reg != LAST_WORD))
        else $error("free-slot scan ran past last word");
`endif

endmodule

/* sim/lowest_free_handle_table_unit_tb.sv */
// Self-checking testbench for the lowest-free handle table unit.
module lowest_free_handle_table_unit_tb;
    import lfht_pkg::*;

    // Opcode 3 has no meaning in the table; it must still answer with one beat.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [31:0] PAYLOAD_MASK = (PAYLOAD_BITS >= 32) ? 32'hFFFF_FFFF
                                         : 32'((64'd1 << PAYLOAD_BITS) - 64'd1);

    localparam int NUM_DIR      = 24;
    localparam int RAND_ITEMS   = 950;
    localparam int IDLE_PCT     = 38;
    localparam int CALM_FIRST   = 120;   // random items with no idling on either side
    localparam int CALM_LAST    = 319;
    localparam int HOLD_AT      = 300;   // result beats seen before the long stall
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_PRINTS   = 100;

    // Worst case per item: full bitmap walk, pipeline, sender gap and receiver stall.
    // The clearing pass after reset comes on top.
    localparam int TOTAL_ITEMS = NUM_DIR + RAND_ITEMS + 16;
    localparam int PER_ITEM    = WORDS + 4 + 40;
    localparam int LIMIT       = 4 * (WORDS + TOTAL_ITEMS * PER_ITEM + HOLD_CYCLES);

    typedef struct {
        lfht_req_t req;
        bit        known;   // expected beat typed in below, not taken from the predictor
        lfht_rsp_t rsp;
    } dir_row_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    lfht_req_t s_payload;
    logic      m_valid;
    logic      m_ready;
    lfht_rsp_t m_payload;

    // Shadow copy of the table
    bit          slot_used [SLOTS];
    bit [31:0]   slot_data [SLOTS];
    int unsigned used_total = 0;
    int          free_hint  = 0;     // no free slot below this index

    lfht_rsp_t   pending_rsp [$];
    dir_row_t    dir_rows [NUM_DIR];

    int mismatches = 0;
    int rsp_seen   = 0;
    int cycles     = 0;
    bit calm       = 1'b0;
    bit hold_done  = 1'b0;

    lowest_free_handle_table_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Apply one request to the shadow table and return the beat it must produce.
    function automatic lfht_rsp_t predict_table(input lfht_req_t r);
        lfht_rsp_t   o;
        int unsigned idx;
        idx            = 32'(r.slot_index);
        o.status       = STATUS_OK;
        o.result_index = r.slot_index[13:0];
        o.result_value = '0;
        case (r.opcode)
            OP_ALLOC: begin
                o.result_index = '0;
                o.status       = STATUS_FULL;
                if (used_total < SLOTS) begin
                    while (slot_used[free_hint]) begin
                        free_hint++;
                    end
                    slot_used[free_hint] = 1'b1;
                    slot_data[free_hint] = r.entry_value & PAYLOAD_MASK;
                    used_total++;
                    o.result_index = 14'(free_hint);
                    o.status       = STATUS_OK;
                    free_hint++;
                end
            end
            OP_LOOKUP, OP_RELEASE: begin
                if (idx >= SLOTS) begin
                    o.status = STATUS_RANGE;
                end else if (!slot_used[idx]) begin
                    o.status = STATUS_FREE;
                end else if (r.opcode == OP_LOOKUP) begin
                    o.result_value = slot_data[idx];
                end else begin
                    slot_used[idx] = 1'b0;
                    if (used_total > 0) begin
                        used_total--;
                    end
                    if (int'(idx) < free_hint) begin
                        free_hint = int'(idx);
                    end
                end
            end
            default: begin
                // unused opcode: echo only, nothing changes
            end
        endcase
        o.used_count = 15'(used_total);
        return o;
    endfunction

    function automatic lfht_req_t make_req(input logic [1:0] op, input int idx,
                                           input logic [31:0] val);
        lfht_req_t r;
        r.opcode      = op;
        r.slot_index  = 15'(idx);
        r.entry_value = val;
        return r;
    endfunction

    function automatic dir_row_t make_row(input logic [1:0] op, input int idx,
                                          input logic [31:0] val, input bit known,
                                          input logic [1:0] st, input int ridx,
                                          input logic [31:0] rval, input int cnt);
        dir_row_t d;
        d.req                = make_req(op, idx, val);
        d.known              = known;
        d.rsp.status         = st;
        d.rsp.result_index   = 14'(ridx);
        d.rsp.result_value   = rval;
        d.rsp.used_count     = 15'(cnt);
        return d;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTS) begin
            $display("mismatch at result beat %0d: %s got %0h want %0h",
                     rsp_seen, what, got, want);
        end
        mismatches++;
    endtask

    // Offer one beat, hold it until taken, then log the expected result.
    // In this task valid drops only in the idle loop, so back-to-back beats keep it high.
    task automatic drive_req(input lfht_req_t r, input bit known, input lfht_rsp_t golden);
        lfht_rsp_t pred;
        while (!calm && ($urandom_range(0, 99) < IDLE_PCT)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= r;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pred = predict_table(r);
        pending_rsp.push_back(known ? golden : pred);
    endtask

    // Result side: every accepted beat is matched against the oldest expectation.
    always @(posedge aclk) begin : check_rsp
        lfht_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            rsp_seen++;
            if (pending_rsp.size() == 0) begin
                report_mismatch("beat with nothing pending",
                                32'(m_payload.result_index), '0);
            end else begin
                want = pending_rsp.pop_front();
                if (m_payload.status !== want.status)
                    report_mismatch("status", 32'(m_payload.status), 32'(want.status));
                if (m_payload.result_index !== want.result_index)
                    report_mismatch("result_index", 32'(m_payload.result_index),
                                    32'(want.result_index));
                if (m_payload.result_value !== want.result_value)
                    report_mismatch("result_value", m_payload.result_value,
                                    want.result_value);
                if (m_payload.used_count !== want.used_count)
                    report_mismatch("used_count", 32'(m_payload.used_count),
                                    32'(want.used_count));
            end
        end
    end

    // Receiver: random backpressure, a calm stretch, and one long hold-off
    // so the unit backs up and drops s_ready while the sender keeps offering.
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if (!hold_done && (rsp_seen >= HOLD_AT)) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
                @(posedge aclk);
            end
        end
    end

    // Watchdog
    initial begin
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int        i;
        int        pick;
        int        idx;
        logic [1:0] op;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;

        // Directed rows. Typed-in rows carry a hand-written expected beat, counted from
        // the empty table after reset; the rest are checked by the predictor.
        dir_rows = '{
            // empty table: free slot, both ends of the out-of-range band, unused opcode
            make_row(OP_LOOKUP,  0,      32'h0,         1, STATUS_FREE,  0,      32'h0, 0),
            make_row(OP_RELEASE, 5,      32'h0,         1, STATUS_FREE,  5,      32'h0, 0),
            make_row(OP_LOOKUP,  16384,  32'hFFFF_FFFF, 1, STATUS_RANGE, 0,      32'h0, 0),
            make_row(OP_RELEASE, 32767,  32'hFFFF_FFFF, 1, STATUS_RANGE, 16383,  32'h0, 0),
            make_row(OP_UNUSED,  'h2AAA, 32'hFFFF_FFFF, 1, STATUS_OK,    'h2AAA, 32'h0, 0),
            // allocates fill from slot 0 up, index field ignored; lookups read them back
            make_row(OP_ALLOC,   0,      32'h0,         1, STATUS_OK,    0,      32'h0, 1),
            make_row(OP_ALLOC,   32767,  32'hFFFF_FFFF, 1, STATUS_OK,    1,      32'h0, 2),
            make_row(OP_ALLOC,   'h5555, 32'h8000_0001, 1, STATUS_OK,    2,      32'h0, 3),
            make_row(OP_LOOKUP,  0,      32'hFFFF_FFFF, 1, STATUS_OK,    0,      32'h0, 3),
            make_row(OP_LOOKUP,  1,      32'h0,         1, STATUS_OK,    1, 32'hFFFF_FFFF, 3),
            make_row(OP_LOOKUP,  16383,  32'h0,         1, STATUS_FREE,  16383,  32'h0, 3),
            // release, then a double release and lookup of the freed slot
            make_row(OP_RELEASE, 1,      32'h0,         1, STATUS_OK,    1,      32'h0, 2),
            make_row(OP_LOOKUP,  1,      32'h0,         1, STATUS_FREE,  1,      32'h0, 2),
            make_row(OP_RELEASE, 1,      32'h0,         1, STATUS_FREE,  1,      32'h0, 2),
            // the hole at slot 1 is reused first
            make_row(OP_ALLOC,   0,      32'h5555_AAAA, 1, STATUS_OK,    1,      32'h0, 3),
            make_row(OP_LOOKUP,  1,      32'h0,         1, STATUS_OK,    1, 32'h5555_AAAA, 3),
            make_row(OP_UNUSED,  32767,  32'h0,         1, STATUS_OK,    16383,  32'h0, 3),
            make_row(OP_LOOKUP,  'h4001, 32'h0,         1, STATUS_RANGE, 1,      32'h0, 3),
            make_row(OP_ALLOC,   0,      32'h1234_5678, 0, STATUS_OK,    0,      32'h0, 0),
            make_row(OP_RELEASE, 0,      32'h0,         0, STATUS_OK,    0,      32'h0, 0),
            make_row(OP_RELEASE, 2,      32'h0,         0, STATUS_OK,    0,      32'h0, 0),
            make_row(OP_ALLOC,   'h7FFF, 32'hDEAD_BEEF, 0, STATUS_OK,    0,      32'h0, 0),
            make_row(OP_LOOKUP,  3,      32'h0,         0, STATUS_OK,    0,      32'h0, 0),
            make_row(OP_LOOKUP,  0,      32'h0,         0, STATUS_OK,    0,      32'h0, 0)
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // s_ready stays low through the bitmap clear; drive_req just waits it out.
        for (i = 0; i < NUM_DIR; i++) begin
            drive_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].rsp);
        end

        // Random traffic. Most indexes land near the occupied low slots so that
        // lookups and releases hit live entries; the rest sweep the whole field.
        for (i = 0; i < RAND_ITEMS; i++) begin
            calm = (i >= CALM_FIRST) && (i <= CALM_LAST);
            if (i == RAND_ITEMS / 2) begin
                // sender pause: let the unit drain completely
                s_valid <= 1'b0;
                while (pending_rsp.size() != 0) @(posedge aclk);
                @(posedge aclk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 36)      op = OP_ALLOC;
            else if (pick < 64) op = OP_LOOKUP;
            else if (pick < 95) op = OP_RELEASE;
            else                op = OP_UNUSED;
            pick = $urandom_range(0, 99);
            if (pick < 75)      idx = $urandom_range(0, used_total + 8);
            else if (pick < 88) idx = $urandom_range(0, 32767);
            else if (pick < 96) idx = $urandom_range(SLOTS, 32767);
            else                idx = $urandom_range(SLOTS - 1, SLOTS);
            drive_req(make_req(op, idx, $urandom), 1'b0, '0);
        end
        calm = 1'b0;

        // The top slot, and a freed low slot followed by an allocate and a lookup of it.
        drive_req(make_req(OP_LOOKUP,  SLOTS - 1, $urandom), 1'b0, '0);
        drive_req(make_req(OP_RELEASE, SLOTS - 1, $urandom), 1'b0, '0);
        drive_req(make_req(OP_RELEASE, 7, $urandom), 1'b0, '0);
        drive_req(make_req(OP_ALLOC,   0, $urandom), 1'b0, '0);
        drive_req(make_req(OP_LOOKUP,  7, $urandom), 1'b0, '0);
        s_valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/lfht_pkg.sv
hdl/lfht_ram.sv
hdl/lowest_free_handle_table_unit.sv
sim/lowest_free_handle_table_unit_tb.sv
